### rtl/core/bmp565_pkg.sv
`timescale 1ns / 1ps

package bmp565_pkg;

  // default configuration of the core
  localparam int DEF_SCREEN_WIDTH    = 128;
  localparam int DEF_SCREEN_HEIGHT   = 160;
  localparam int DEF_MAX_IMAGE_WIDTH = 1280;
  localparam int DEF_COLUMN_OFFSET   = 0;
  localparam int DEF_ROW_OFFSET      = 0;
  localparam int DEF_QUEUE_DEPTH     = 4;

  // parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_REJECT = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // display command codes
  localparam logic [15:0] CMD_WIN_H = 16'h0044;
  localparam logic [15:0] CMD_WIN_V = 16'h0045;
  localparam logic [15:0] CMD_ADDR  = 16'h0021;
  localparam logic [15:0] CMD_WRITE = 16'h0022;

  // work for the back end, produced by one input byte
  typedef struct packed {
    logic        burst;
    logic        pix;
    logic        fin;
    logic        rej;
    logic [7:0]  xs;
    logic [7:0]  xe;
    logic [7:0]  y;
    logic [15:0] pix_word;
  } job_t;

endpackage

### rtl/core/bmp24_to_rgb565_display_stream_core.sv
`timescale 1ns / 1ps

// Converts a 24-bit BMP file, fed one byte per transfer, into display bus words. The header
// is checked (one plane, 24 bpp, no compression, width 1 to MAX_IMAGE_WIDTH, nonzero height,
// pixel offset past byte 33); a bad header gives one reject result on byte 33. The image is
// centred and cropped on a SCREEN_WIDTH x SCREEN_HEIGHT panel and sent bottom row first; each
// shown row opens with a 7-word window burst (0x0044, x window, 0x0045, y window, 0x0021,
// address, 0x0022) and then one RGB565 word per shown pixel, with the finish result after the
// last pixel of the top row. start_of_file high restarts the parser on that byte. The input
// side takes one byte per clock while full is low; the output side hands out one result per
// clock while pop is high and empty is low. Each byte that causes results leaves a job in a
// QUEUE_DEPTH-entry queue, and its entry is freed when the last result of that job is
// handed out, so full rises only when the queue holds QUEUE_DEPTH unfinished jobs.
module bmp24_to_rgb565_display_stream_core #(
  parameter int SCREEN_WIDTH    = bmp565_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = bmp565_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_IMAGE_WIDTH = bmp565_pkg::DEF_MAX_IMAGE_WIDTH,
  parameter int COLUMN_OFFSET   = bmp565_pkg::DEF_COLUMN_OFFSET,
  parameter int ROW_OFFSET      = bmp565_pkg::DEF_ROW_OFFSET,
  parameter int QUEUE_DEPTH     = bmp565_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  file_byte,
  input  logic        start_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] bus_word,
  output logic        burst_last
);

  logic             accept;
  logic             job_push;
  bmp565_pkg::job_t job_in, job_head;
  logic             head_valid, head_done;

  // input transfer
  assign accept = push && !full;

  // header parser and pixel packer
  bmp565_front #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
    .COLUMN_OFFSET   (COLUMN_OFFSET),
    .ROW_OFFSET      (ROW_OFFSET)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .file_byte     (file_byte),
    .start_of_file (start_of_file),
    .job_push      (job_push),
    .job           (job_in)
  );

  // job queue between parser and word sequencer
  bmp565_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_job    (job_in),
    .rd_en     (head_done),
    .rd_job    (job_head),
    .not_empty (head_valid),
    .is_full   (full)
  );

  // bus word sequencer
  bmp565_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (job_head),
    .head_valid (head_valid),
    .head_done  (head_done),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .bus_word   (bus_word),
    .burst_last (burst_last)
  );

endmodule

### rtl/core/bmp565_front.sv
`timescale 1ns / 1ps

module bmp565_front #(
  parameter int SCREEN_WIDTH    = bmp565_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = bmp565_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_IMAGE_WIDTH = bmp565_pkg::DEF_MAX_IMAGE_WIDTH,
  parameter int COLUMN_OFFSET   = bmp565_pkg::DEF_COLUMN_OFFSET,
  parameter int ROW_OFFSET      = bmp565_pkg::DEF_ROW_OFFSET
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        file_byte,
  input  logic              start_of_file,
  output logic              job_push,
  output bmp565_pkg::job_t  job
);

  localparam int IW  = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int SW  = $clog2(3 * MAX_IMAGE_WIDTH + 4);
  localparam int XW  = $clog2(SCREEN_WIDTH + 1);
  localparam int S3W = $clog2(3 * SCREEN_WIDTH);
  localparam int RW  = $clog2(SCREEN_HEIGHT + 1);

  // header byte positions
  localparam logic [5:0] POS_OFS_LO   = 6'd10;
  localparam logic [5:0] POS_OFS_HI   = 6'd13;
  localparam logic [5:0] POS_OFS_CHK  = 6'd14;
  localparam logic [5:0] POS_WID_LO   = 6'd18;
  localparam logic [5:0] POS_WID_HI   = 6'd21;
  localparam logic [5:0] POS_HGT_LO   = 6'd22;
  localparam logic [5:0] POS_HGT_HI   = 6'd25;
  localparam logic [5:0] POS_PLANES   = 6'd26;
  localparam logic [5:0] POS_PLANES_H = 6'd27;
  localparam logic [5:0] POS_BPP      = 6'd28;
  localparam logic [5:0] POS_BPP_H    = 6'd29;
  localparam logic [5:0] POS_END      = 6'd33;
  localparam logic [31:0] HEADER_END  = 32'd33;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] ONE_PLANE    = 8'd1;

  // state registers
  logic [31:0]    pos, pos_next;
  logic [2:0]     phase, phase_next;
  logic [31:0]    offset, offset_next;
  logic [31:0]    width_word, width_word_next;
  logic [31:0]    height, height_next;
  logic           bad, bad_next;
  logic [SW-1:0]  stride, stride_next;
  logic [S3W-1:0] shown3m1, shown3m1_next;
  logic [7:0]     xs_o, xs_o_next;
  logic [7:0]     xe_o, xe_o_next;
  logic [RW-1:0]  cur_row, cur_row_next;
  logic [RW-1:0]  rows, rows_next;
  logic [31:0]    skip, skip_next;
  logic [SW-1:0]  bir, bir_next;
  logic [1:0]     sub, sub_next;
  logic [10:0]    acc, acc_next;

  // values seen by this byte, with a file start applied
  logic [2:0]  phase_e;
  logic [31:0] pos_e, offset_e, width_e, height_e;
  logic        bad_e;
  logic [5:0]  pos6;
  logic [1:0]  lane;

  assign phase_e  = start_of_file ? bmp565_pkg::PH_HEADER : phase;
  assign pos_e    = start_of_file ? '0 : pos;
  assign offset_e = start_of_file ? '0 : offset;
  assign width_e  = start_of_file ? '0 : width_word;
  assign height_e = start_of_file ? '0 : height;
  assign bad_e    = start_of_file ? 1'b0 : bad;
  assign pos6     = pos_e[5:0];
  assign lane     = pos6[1:0] + 2'd2;

  // image geometry from the collected width
  logic [IW-1:0]  w;
  logic           w_wide, w_bad;
  logic [SW-1:0]  w_stride;
  logic [XW-1:0]  shown, xs_w, xe_w;
  logic [S3W-1:0] w_shown3m1;

  always_comb begin
    w          = width_e[IW-1:0];
    w_bad      = (width_e == 32'd0) || (width_e > 32'(MAX_IMAGE_WIDTH));
    w_wide     = 32'(w) > 32'(SCREEN_WIDTH);
    w_stride   = (SW'(w) << 1) + SW'(w) + SW'(3);
    w_stride   = {w_stride[SW-1:2], 2'b00};
    if (w_wide) begin
      shown = XW'(SCREEN_WIDTH);
      xs_w  = '0;
      xe_w  = XW'(SCREEN_WIDTH - 1);
    end else begin
      shown = XW'(w);
      xs_w  = (XW'(SCREEN_WIDTH) - XW'(w)) >> 1;
      xe_w  = xs_w + XW'(w) - XW'(1);
    end
    w_shown3m1 = S3W'((32'(shown) << 1) + 32'(shown) - 32'd1);
  end

  // vertical geometry from the collected height
  logic          h_tall;
  logic [RW-1:0] hn, ys_h, ye_h;

  always_comb begin
    h_tall = height_e > 32'(SCREEN_HEIGHT);
    hn     = RW'(height_e);
    ys_h   = (RW'(SCREEN_HEIGHT) - hn) >> 1;
    ye_h   = ys_h + hn - RW'(1);
  end

  // parser next state and job for the back end
  logic          do_data;
  logic [SW-1:0] bir_inc;
  logic          wrap;
  logic [15:0]   pix_word;

  always_comb begin
    pos_next        = (&pos_e) ? pos_e : pos_e + 32'd1;
    phase_next      = phase_e;
    offset_next     = offset_e;
    width_word_next = width_e;
    height_next     = height_e;
    bad_next        = bad_e;
    stride_next     = stride;
    shown3m1_next   = shown3m1;
    xs_o_next       = xs_o;
    xe_o_next       = xe_o;
    cur_row_next    = cur_row;
    rows_next       = rows;
    skip_next       = skip;
    bir_next        = bir;
    sub_next        = sub;
    acc_next        = acc;
    do_data         = 1'b0;
    bir_inc         = bir + SW'(1);
    wrap            = bir_inc >= stride;
    pix_word        = {file_byte[7:3], acc};

    job          = '0;
    job.xs       = xs_o;
    job.xe       = xe_o;
    job.y        = 8'(32'(ROW_OFFSET) + 32'(cur_row));
    job.pix_word = pix_word;

    case (phase_e)
      bmp565_pkg::PH_HEADER: begin
        if (pos6 >= POS_OFS_LO && pos6 <= POS_OFS_HI) begin
          offset_next[8*lane +: 8] = file_byte;
        end else if (pos6 >= POS_WID_LO && pos6 <= POS_WID_HI) begin
          width_word_next[8*lane +: 8] = file_byte;
        end else if (pos6 >= POS_HGT_LO && pos6 <= POS_HGT_HI) begin
          height_next[8*lane +: 8] = file_byte;
        end
        // offset must lie past the checked header
        if (pos6 == POS_OFS_CHK && offset_e <= HEADER_END) begin
          bad_next = 1'b1;
        end
        // planes byte: also settle the horizontal geometry
        if (pos6 == POS_PLANES) begin
          if (file_byte != ONE_PLANE || w_bad) begin
            bad_next = 1'b1;
          end
          stride_next   = w_stride;
          shown3m1_next = w_shown3m1;
          xs_o_next     = 8'(32'(COLUMN_OFFSET) + 32'(xs_w));
          xe_o_next     = 8'(32'(COLUMN_OFFSET) + 32'(xe_w));
        end
        // high planes byte: also settle the vertical geometry
        if (pos6 == POS_PLANES_H) begin
          if (file_byte != 8'd0 || height_e == 32'd0) begin
            bad_next = 1'b1;
          end
          if (h_tall) begin
            skip_next    = height_e - 32'(SCREEN_HEIGHT);
            cur_row_next = RW'(SCREEN_HEIGHT - 1);
            rows_next    = RW'(SCREEN_HEIGHT);
          end else begin
            skip_next    = '0;
            cur_row_next = ye_h;
            rows_next    = hn;
          end
        end
        if (pos6 == POS_BPP && file_byte != BPP_24) begin
          bad_next = 1'b1;
        end
        if (pos6 >= POS_BPP_H && pos6 <= POS_END && file_byte != 8'd0) begin
          bad_next = 1'b1;
        end
        // header judged on its last byte
        if (pos6 == POS_END) begin
          if (bad_next) begin
            job.rej    = 1'b1;
            phase_next = bmp565_pkg::PH_REJECT;
          end else begin
            phase_next = bmp565_pkg::PH_WAIT;
            bir_next   = '0;
            sub_next   = '0;
          end
        end
      end
      bmp565_pkg::PH_WAIT: begin
        if (pos_e == offset) begin
          phase_next = bmp565_pkg::PH_DATA;
          do_data    = 1'b1;
        end
      end
      bmp565_pkg::PH_DATA: begin
        do_data = 1'b1;
      end
      default: begin
      end
    endcase

    // pixel data
    if (do_data) begin
      if (skip != 32'd0) begin
        // bottom rows beyond the screen
        bir_next = wrap ? '0 : bir_inc;
        sub_next = '0;
        if (wrap) begin
          skip_next = skip - 32'd1;
        end
      end else begin
        job.burst = (bir == '0);
        if (32'(bir) <= 32'(shown3m1)) begin
          case (sub)
            2'd0: acc_next = {6'd0, file_byte[7:3]};
            2'd1: acc_next = {file_byte[7:2], acc[4:0]};
            default: begin
              job.pix = 1'b1;
            end
          endcase
        end
        if (job.pix && 32'(bir) == 32'(shown3m1) && rows <= RW'(1)) begin
          job.fin    = 1'b1;
          rows_next  = '0;
          phase_next = bmp565_pkg::PH_DONE;
        end else begin
          bir_next = wrap ? '0 : bir_inc;
          sub_next = (wrap || sub == 2'd2) ? 2'd0 : sub + 2'd1;
          if (wrap) begin
            cur_row_next = cur_row - RW'(1);
            rows_next    = rows - RW'(1);
          end
        end
      end
    end
  end

  assign job_push = accept && (job.burst || job.pix || job.fin || job.rej);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      phase <= bmp565_pkg::PH_HEADER;
      bad   <= 1'b0;
    end else if (accept) begin
      pos   <= pos_next;
      phase <= phase_next;
      bad   <= bad_next;
    end
  end

  // header collectors and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      offset     <= '0;
      width_word <= '0;
      height     <= '0;
      skip       <= '0;
      rows       <= '0;
      cur_row    <= '0;
      bir        <= '0;
      sub        <= '0;
    end else if (accept) begin
      offset     <= offset_next;
      width_word <= width_word_next;
      height     <= height_next;
      skip       <= skip_next;
      rows       <= rows_next;
      cur_row    <= cur_row_next;
      bir        <= bir_next;
      sub        <= sub_next;
    end
  end

  // geometry and pixel payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stride   <= stride_next;
      shown3m1 <= shown3m1_next;
      xs_o     <= xs_o_next;
      xe_o     <= xe_o_next;
      acc      <= acc_next;
    end
  end

endmodule

### rtl/core/bmp565_queue.sv
`timescale 1ns / 1ps

module bmp565_queue #(
  parameter int DEPTH = bmp565_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  bmp565_pkg::job_t wr_job,
  input  logic             rd_en,
  output bmp565_pkg::job_t rd_job,
  output logic             not_empty,
  output logic             is_full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bmp565_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign rd_job    = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign is_full   = (count == CW'(DEPTH));

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

### rtl/core/bmp565_back.sv
`timescale 1ns / 1ps

module bmp565_back (
  input  logic             clk,
  input  logic             rst,
  input  bmp565_pkg::job_t head,
  input  logic             head_valid,
  output logic             head_done,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       kind,
  output logic [15:0]      bus_word,
  output logic             burst_last
);

  // result steps of one job
  localparam logic [3:0] STEP_WIN_H = 4'd0;
  localparam logic [3:0] STEP_XWORD = 4'd1;
  localparam logic [3:0] STEP_WIN_V = 4'd2;
  localparam logic [3:0] STEP_YWORD = 4'd3;
  localparam logic [3:0] STEP_ADDR  = 4'd4;
  localparam logic [3:0] STEP_AWORD = 4'd5;
  localparam logic [3:0] STEP_WRITE = 4'd6;
  localparam logic [3:0] STEP_PIX   = 4'd7;
  localparam logic [3:0] STEP_FIN   = 4'd8;
  localparam logic [3:0] STEP_REJ   = 4'd9;
  localparam logic [3:0] STEP_END   = 4'd15;

  logic       started;
  logic [3:0] step;
  logic [3:0] first_step, cur, nxt;
  logic       take;

  // first step of the head job
  always_comb begin
    if (head.burst) begin
      first_step = STEP_WIN_H;
    end else if (head.pix) begin
      first_step = STEP_PIX;
    end else if (head.fin) begin
      first_step = STEP_FIN;
    end else begin
      first_step = STEP_REJ;
    end
  end

  assign cur = started ? step : first_step;

  // step that follows the current one
  always_comb begin
    case (cur)
      STEP_WIN_H, STEP_XWORD, STEP_WIN_V, STEP_YWORD, STEP_ADDR, STEP_AWORD: begin
        nxt = cur + 4'd1;
      end
      STEP_WRITE: begin
        nxt = head.pix ? STEP_PIX : (head.fin ? STEP_FIN : STEP_END);
      end
      STEP_PIX: begin
        nxt = head.fin ? STEP_FIN : STEP_END;
      end
      default: begin
        nxt = STEP_END;
      end
    endcase
  end

  // result word of the current step
  always_comb begin
    case (cur)
      STEP_WIN_H: begin
        kind     = bmp565_pkg::KIND_CMD;
        bus_word = bmp565_pkg::CMD_WIN_H;
      end
      STEP_XWORD: begin
        kind     = bmp565_pkg::KIND_DATA;
        bus_word = {head.xe, head.xs};
      end
      STEP_WIN_V: begin
        kind     = bmp565_pkg::KIND_CMD;
        bus_word = bmp565_pkg::CMD_WIN_V;
      end
      STEP_YWORD: begin
        kind     = bmp565_pkg::KIND_DATA;
        bus_word = {head.y, head.y};
      end
      STEP_ADDR: begin
        kind     = bmp565_pkg::KIND_CMD;
        bus_word = bmp565_pkg::CMD_ADDR;
      end
      STEP_AWORD: begin
        kind     = bmp565_pkg::KIND_DATA;
        bus_word = {head.y, head.xs};
      end
      STEP_WRITE: begin
        kind     = bmp565_pkg::KIND_CMD;
        bus_word = bmp565_pkg::CMD_WRITE;
      end
      STEP_PIX: begin
        kind     = bmp565_pkg::KIND_DATA;
        bus_word = head.pix_word;
      end
      STEP_FIN: begin
        kind     = bmp565_pkg::KIND_DONE;
        bus_word = '0;
      end
      default: begin
        kind     = bmp565_pkg::KIND_REJECT;
        bus_word = '0;
      end
    endcase
  end

  assign empty      = !head_valid;
  assign burst_last = (nxt == STEP_END);
  assign take       = pop && head_valid;
  assign head_done  = take && burst_last;

  // walk through the steps of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      step    <= STEP_WIN_H;
    end else if (take) begin
      started <= !burst_last;
      step    <= nxt;
    end
  end

endmodule
